/* sv/fie_pkg.sv */
// shared types, constants and helpers for the fixation index estimator
`timescale 1ns / 1ps
package fie_pkg;

  localparam int MaxSamples = 4096;
  localparam int SampleW = 13;
  localparam int DoseW = 10;
  localparam int SumW = 22;
  localparam int FreqW = 21;
  localparam int TotalW = 64;
  localparam int FstW = 32;
  localparam int DivW = 33;
  localparam int QuoW = 34;
  localparam int DivSteps = 88;
  localparam int FracShift = 24;

  localparam logic [FreqW-1:0] FreqOne = FreqW'(1 << 20);
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  localparam logic CfgSamplesOne = 1'b0;
  localparam logic CfgSamplesTwo = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FREQ,
    ST_PROD,
    ST_TERM,
    ST_ACC,
    ST_DIV_INIT,
    ST_DIV,
    ST_OUT
  } fie_state_t;

  typedef struct packed {
    logic accept;
    logic close;
    logic freq_start;
    logic prod_load;
    logic term_load;
    logic acc_add;
    logic div_init;
    logic div_start;
    logic out_load;
  } fie_cmd_t;

  typedef struct packed {
    logic divu_done;
    logic den_nonpos;
  } fie_status_t;

  function automatic logic [SampleW-1:0] clamp_samples(input logic [SampleW-1:0] n);
    logic [SampleW-1:0] r;
    r = n;
    if (n < SampleW'(2)) r = SampleW'(2);
    else if (n > SampleW'(MaxSamples)) r = SampleW'(MaxSamples);
    return r;
  endfunction

endpackage

/* sv/fixation_index_estimator_top.sv */
// top level of the fixation index estimator
`timescale 1ns / 1ps
// a plain dosage is taken without stalling; a marker end stalls the input while
// four 64-step divisions run one after another on the shared divider; a set end
// then runs the 88-step final quotient unless the denominator is not positive, and
// out_valid rises after it, later if the previous result still waits
// throughput: one dosage per cycle inside a marker, input stalled during closing
// reset: rst is synchronous and active high; sums and totals clear, counts go to 2
module fixation_index_estimator_top import fie_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               population,
  input  logic [DoseW-1:0]   dosage,
  input  logic               marker_end,
  input  logic               set_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [FstW-1:0] fst,
  output logic               denominator_zero,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [SampleW-1:0] cfg_data
);

  fie_cmd_t cmd;
  fie_status_t status;

  // configuration is always taken; the user must write it only while idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  fie_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .marker_end   (marker_end),
    .set_end      (set_end),
    .out_stall    (out_stall),
    .status       (status),
    .cmd          (cmd),
    .in_stall     (in_stall),
    .out_valid    (out_valid)
  );

  fie_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_sel          (cfg_index),
    .cfg_data         (cfg_data),
    .population       (population),
    .dosage           (dosage),
    .fst              (fst),
    .denominator_zero (denominator_zero),
    .saturated        (saturated)
  );

  // a result never claims both a zero denominator and clipping
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(denominator_zero && saturated))
    else $error("zero denominator and saturation both set");

  // a stalled result stays and keeps its value
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(fst)))
    else $error("stalled result dropped or changed");

  // zero denominator result carries zero estimate
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && denominator_zero) |-> (fst == '0))
    else $error("nonzero estimate with zero denominator");

endmodule

/* sv/fie_divider.sv */
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
module fie_divider import fie_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TotalW-1:0] dividend,
  input  logic [TotalW-1:0] divisor,
  input  logic [6:0]        steps,
  output logic              done,
  output logic [TotalW-1:0] quotient
);

  logic [TotalW-1:0] rem;
  logic [TotalW-1:0] num;
  logic [TotalW-1:0] den;
  logic [6:0] count;
  logic busy;
  logic [TotalW:0] shifted;
  logic [TotalW:0] diff;

  always_comb begin
    shifted = {rem, num[TotalW-1]};
    diff = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= steps;
      end else if (busy) begin
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      num <= dividend;
      den <= divisor;
      quotient <= '0;
    end else if (busy) begin
      num <= {num[TotalW-2:0], 1'b0};
      if (!diff[TotalW]) begin
        rem <= diff[TotalW-1:0];
        quotient <= {quotient[TotalW-2:0], 1'b1};
      end else begin
        rem <= shifted[TotalW-1:0];
        quotient <= {quotient[TotalW-2:0], 1'b0};
      end
    end
  end

endmodule

/* sv/fie_datapath.sv */
// accumulators, per-marker arithmetic and final quotient
`timescale 1ns / 1ps
module fie_datapath import fie_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  fie_cmd_t           cmd,
  output fie_status_t        status,
  input  logic               cfg_we,
  input  logic               cfg_sel,
  input  logic [SampleW-1:0] cfg_data,
  input  logic               population,
  input  logic [DoseW-1:0]   dosage,
  output logic signed [FstW-1:0] fst,
  output logic               denominator_zero,
  output logic               saturated
);

  logic [SampleW-1:0] n1_reg;
  logic [SampleW-1:0] n2_reg;
  logic [SampleW-1:0] n1;
  logic [SampleW-1:0] n2;
  logic [SumW-1:0] sum1;
  logic [SumW-1:0] sum2;
  logic [SumW:0] add_val;
  logic [FreqW-1:0] p1;
  logic [FreqW-1:0] p2;
  logic [2*FreqW-1:0] sq;
  logic [2*FreqW-1:0] pq1;
  logic [2*FreqW-1:0] pq2;
  logic [2*FreqW-1:0] cross1;
  logic [2*FreqW-1:0] cross2;
  logic [2*FreqW-1:0] t2;
  logic [2*FreqW-1:0] t3;
  logic signed [TotalW-1:0] num_total;
  logic signed [TotalW-1:0] den_total;
  logic signed [TotalW:0] num_sum;
  logic signed [TotalW:0] den_sum;
  logic signed [TotalW:0] delta;
  logic neg;
  logic [TotalW-1:0] mag;
  logic [3:0] phase;
  logic div_go;
  logic [TotalW-1:0] div_a;
  logic [TotalW-1:0] div_b;
  logic [6:0] div_steps;
  logic div_done;
  logic [TotalW-1:0] div_q;
  logic [FreqW-1:0] diff;
  logic [FreqW-1:0] p_next;
  logic [TotalW+FracShift-1:0] big_num;

  always_comb begin
    n1 = clamp_samples(n1_reg);
    n2 = clamp_samples(n2_reg);
    add_val = {1'b0, population ? sum2 : sum1} + (SumW+1)'(dosage);
    diff = (p1 > p2) ? p1 - p2 : p2 - p1;
    delta = (TotalW+1)'($signed({1'b0, sq})) - (TotalW+1)'($signed({1'b0, t2}))
          - (TotalW+1)'($signed({1'b0, t3}));
    num_sum = (TotalW+1)'(num_total) + delta;
    den_sum = (TotalW+1)'(den_total) + (TotalW+1)'($signed({1'b0, cross1}))
            + (TotalW+1)'($signed({1'b0, cross2}));
    p_next = (div_q > TotalW'(FreqOne)) ? FreqOne : div_q[FreqW-1:0];
    mag = num_total[TotalW-1] ? TotalW'(0) - num_total : num_total;
    big_num = {mag, {FracShift{1'b0}}};
  end

  // shared divider: phases 1 and 2 give the frequencies, 3 and 4 the variance terms
  always_comb begin
    div_go = 1'b0;
    div_a = '0;
    div_b = TotalW'(1);
    div_steps = 7'd64;
    unique case (phase)
      4'd1: begin div_go = 1'b1; div_a = TotalW'({sum1, 11'b0}); div_b = TotalW'(n1); end
      4'd2: begin div_go = 1'b1; div_a = TotalW'({sum2, 11'b0}); div_b = TotalW'(n2); end
      4'd3: begin div_go = 1'b1; div_a = TotalW'(pq1); div_b = TotalW'(n1 - 13'd1); end
      4'd4: begin div_go = 1'b1; div_a = TotalW'(pq2); div_b = TotalW'(n2 - 13'd1); end
      default: ;
    endcase
  end

  // final quotient runs on a wider unit: 88 steps over mag * 2^24
  logic [TotalW+FracShift-1:0] fnum;
  logic [TotalW:0] frem;
  logic [QuoW-1:0] fquo;
  logic [6:0] fcount;
  logic fbusy;
  logic fdone;
  logic fbig;
  logic [TotalW+1:0] fshift;
  logic [TotalW+1:0] fdiff;
  logic [QuoW-1:0] fq_next;
  logic [TotalW-1:0] fden;

  always_comb begin
    fshift = {frem, fnum[$high(fnum)]};
    fdiff = fshift - {2'b0, fden};
    fq_next = {fquo[QuoW-2:0], ~fdiff[TotalW+1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fbusy <= 1'b0;
      fdone <= 1'b0;
      fcount <= '0;
    end else begin
      fdone <= 1'b0;
      if (cmd.div_start) begin
        fbusy <= 1'b1;
        fcount <= 7'(DivSteps);
      end else if (fbusy) begin
        fcount <= fcount - 7'd1;
        if (fcount == 7'd1) begin
          fbusy <= 1'b0;
          fdone <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      fnum <= big_num;
      frem <= '0;
      fquo <= '0;
      fden <= den_total;
      fbig <= 1'b0;
    end else if (fbusy) begin
      fnum <= {fnum[$high(fnum)-1:0], 1'b0};
      frem <= fdiff[TotalW+1] ? fshift[TotalW:0] : fdiff[TotalW:0];
      if (fbig || fq_next > QuoW'(33'h80000000)) begin
        fbig <= 1'b1;
        fquo <= QuoW'(33'h80000001);
      end else begin
        fquo <= fq_next;
      end
    end
  end

  fie_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go && cmd.freq_start),
    .dividend (div_a),
    .divisor  (div_b),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    status.divu_done = div_done || fdone;
    status.den_nonpos = (den_total <= 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_reg <= SampleW'(2);
      n2_reg <= SampleW'(2);
      sum1 <= '0;
      sum2 <= '0;
      num_total <= '0;
      den_total <= '0;
      phase <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_sel == CfgSamplesOne) n1_reg <= cfg_data;
        else n2_reg <= cfg_data;
      end
      if (cmd.accept) begin
        if (population) sum2 <= add_val[SumW] ? SumMax : add_val[SumW-1:0];
        else sum1 <= add_val[SumW] ? SumMax : add_val[SumW-1:0];
      end
      if (cmd.close) phase <= 4'd1;
      if (div_done) begin
        unique case (phase)
          4'd1: begin p1 <= p_next; phase <= 4'd2; end
          4'd2: begin p2 <= p_next; phase <= 4'd5; end
          4'd3: begin t2 <= div_q[2*FreqW-1:0]; phase <= 4'd4; end
          4'd4: begin t3 <= div_q[2*FreqW-1:0]; phase <= 4'd0; end
          default: ;
        endcase
      end
      if (cmd.term_load) phase <= 4'd3;
      if (cmd.acc_add) begin
        num_total <= num_sum[TotalW] != num_sum[TotalW-1]
          ? (num_sum[TotalW] ? {1'b1, {(TotalW-1){1'b0}}} : {1'b0, {(TotalW-1){1'b1}}})
          : num_sum[TotalW-1:0];
        den_total <= den_sum[TotalW] != den_sum[TotalW-1]
          ? (den_sum[TotalW] ? {1'b1, {(TotalW-1){1'b0}}} : {1'b0, {(TotalW-1){1'b1}}})
          : den_sum[TotalW-1:0];
        sum1 <= '0;
        sum2 <= '0;
      end
      if (cmd.out_load) begin
        num_total <= '0;
        den_total <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_load) begin
      sq <= diff * diff;
      pq1 <= p1 * (FreqOne - p1);
      pq2 <= p2 * (FreqOne - p2);
      cross1 <= p1 * (FreqOne - p2);
      cross2 <= p2 * (FreqOne - p1);
    end
    if (cmd.div_init) begin
      neg <= num_total[TotalW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (status.den_nonpos) begin
        fst <= '0;
        denominator_zero <= 1'b1;
        saturated <= 1'b0;
      end else begin
        denominator_zero <= 1'b0;
        if (neg) begin
          if (fquo > QuoW'(33'h80000000)) begin
            fst <= {1'b1, {(FstW-1){1'b0}}};
            saturated <= 1'b1;
          end else begin
            fst <= FstW'(QuoW'(0) - fquo);
            saturated <= 1'b0;
          end
        end else begin
          if (fquo > QuoW'(33'h7FFFFFFF)) begin
            fst <= {1'b0, {(FstW-1){1'b1}}};
            saturated <= 1'b1;
          end else begin
            fst <= FstW'(fquo);
            saturated <= 1'b0;
          end
        end
      end
    end
  end

endmodule

/* sv/fie_controller.sv */
// sequencing state machine for marker close and final division
`timescale 1ns / 1ps
module fie_controller import fie_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        marker_end,
  input  logic        set_end,
  input  logic        out_stall,
  input  fie_status_t status,
  output fie_cmd_t    cmd,
  output logic        in_stall,
  output logic        out_valid
);

  fie_state_t state;
  fie_state_t state_next;
  logic emit_flag;
  logic emit_next;
  logic [1:0] wait_count;
  logic out_pending;
  logic out_free;

  // the result register can take a new value once the old one leaves
  assign out_free = !out_pending || !out_stall;

  always_comb begin
    state_next = state;
    emit_next = emit_flag;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && (marker_end || set_end)) begin
          state_next = ST_FREQ;
          emit_next = set_end;
        end
      end
      ST_FREQ:  if (status.divu_done && wait_count == 2'd3) state_next = ST_PROD;
      ST_PROD:  state_next = ST_TERM;
      ST_TERM:  if (status.divu_done && wait_count == 2'd3) state_next = ST_ACC;
      ST_ACC:   state_next = emit_flag ? ST_DIV_INIT : ST_IDLE;
      ST_DIV_INIT: state_next = status.den_nonpos ? ST_OUT : ST_DIV;
      ST_DIV:   if (status.divu_done) state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != ST_IDLE);
    cmd.accept = in_valid && !in_stall;
    cmd.close = cmd.accept && (marker_end || set_end);
    cmd.freq_start = (state == ST_FREQ || state == ST_TERM)
                  && (wait_count == 2'd0 || wait_count == 2'd2);
    cmd.prod_load = (state == ST_PROD);
    cmd.term_load = (state == ST_PROD);
    cmd.acc_add = (state == ST_ACC);
    cmd.div_init = (state == ST_DIV_INIT);
    cmd.div_start = (state == ST_DIV_INIT) && !status.den_nonpos;
    cmd.out_load = (state == ST_OUT) && out_free;
  end

  // two divider runs per wait state; even counts start a run, odd counts wait for it
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      emit_flag <= 1'b0;
      wait_count <= '0;
      out_pending <= 1'b0;
    end else begin
      state <= state_next;
      emit_flag <= emit_next;
      if (state != state_next) wait_count <= '0;
      else if (cmd.freq_start || status.divu_done) wait_count <= wait_count + 2'd1;
      if (cmd.out_load) out_pending <= 1'b1;
      else if (!out_stall) out_pending <= 1'b0;
    end
  end

  assign out_valid = out_pending;

endmodule
